FILE: src/plec_pkg.sv
// shared types and constants for the positional list engine
package plec_pkg;

  // default sizing of the list
  localparam int CAPACITY_DEF   = 128;
  localparam int ENTRY_BITS_DEF = 8;

  // fixed widths of the channel fields
  localparam int OP_BITS     = 3;
  localparam int INDEX_BITS  = 7;
  localparam int VALUE_BITS  = 8;
  localparam int COUNT_BITS  = 8;
  localparam int STATUS_BITS = 2;

  // request operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_SWAP   = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    op_e  op;
    logic commit;
  } cell_cmd_t;

endpackage

FILE: src/plec_req_if.sv
// request channel: operation, positions and entry payload
interface plec_req_if;
  import plec_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    op;
  logic [INDEX_BITS-1:0] index;
  logic [INDEX_BITS-1:0] index_b;
  logic [VALUE_BITS-1:0] entry_value;

  modport source (output valid, op, index, index_b, entry_value, input ready);
  modport sink   (input valid, op, index, index_b, entry_value, output ready);
endinterface

FILE: src/plec_rsp_if.sv
// response channel: read value, entry count and status
interface plec_rsp_if;
  import plec_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  read_value;
  logic [COUNT_BITS-1:0]  entry_count;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

FILE: src/positional_list_engine_core.sv
// top level of the positional list engine: request stage, cell row and response register
//
//  channel  | dir | transfer when      | payload
//  ---------+-----+--------------------+-------------------------------------
//  req_i    | in  | valid && ready     | op, index, index_b, entry_value
//  rsp_o    | out | valid && ready     | read_value, entry_count, status
//
// every request completes from the request register into the response register
// when it commits, so the block takes one transfer per cycle while rsp_o is not
// stalled. all cells shift, load or swap in parallel in the commit cycle.
// reset empties the list (count zero) and clears both valid flags.
// a stalled response holds the request register, which then holds req_i.
module positional_list_engine_core #(
  parameter int CAPACITY   = plec_pkg::CAPACITY_DEF,
  parameter int ENTRY_BITS = plec_pkg::ENTRY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plec_req_if.sink   req_i,
  plec_rsp_if.source rsp_o
);
  import plec_pkg::*;

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  // request register
  logic                  req_valid_q, req_valid_d;
  op_e                   op_q;
  logic [INDEX_BITS-1:0] ia_q, ib_q;
  logic [ENTRY_BITS-1:0] wr_value_q;
  logic [ENTRY_BITS+VALUE_BITS-1:0] wr_ext;

  // list count and response register
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [COUNT_BITS-1:0] out_count_q;
  status_e               out_status_q;

  logic                  accept, commit, is_full, a_out, b_out;
  status_e               status;
  cell_cmd_t             cmd;
  logic [ENTRY_BITS-1:0] cell_val [CAPACITY];
  logic [ENTRY_BITS-1:0] sel_a [CAPACITY];
  logic [ENTRY_BITS-1:0] sel_b [CAPACITY];
  logic [ENTRY_BITS-1:0] val_a, val_b, rd_value;
  logic [ENTRY_BITS+VALUE_BITS-1:0] rd_ext;
  logic [CNT_BITS+COUNT_BITS-1:0]   cnt_ext;

  // handshake
  assign commit      = req_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || commit;
  assign accept      = req_i.valid && req_i.ready;
  assign req_valid_d = accept ? 1'b1 : (commit ? 1'b0 : req_valid_q);
  assign out_valid_d = commit ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  // entry payload fitted to the stored width
  assign wr_ext = {{ENTRY_BITS{1'b0}}, req_i.entry_value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(req_i.op);
      ia_q       <= req_i.index;
      ib_q       <= req_i.index_b;
      wr_value_q <= wr_ext[ENTRY_BITS-1:0];
    end
  end

  // range and capacity checks
  assign is_full = (count_q == CNT_BITS'(CAPACITY));
  assign a_out   = (32'(ia_q) >= 32'(count_q));
  assign b_out   = (32'(ib_q) >= 32'(count_q));

  always_comb begin
    unique case (op_q)
      OP_INSERT: status = a_out ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
      OP_APPEND: status = is_full ? ST_FULL : ST_OK;
      OP_REMOVE: status = a_out ? ST_RANGE : ST_OK;
      OP_READ:   status = a_out ? ST_RANGE : ST_OK;
      OP_SWAP:   status = (a_out || b_out) ? ST_RANGE : ST_OK;
      default:   status = ST_OK;
    endcase
  end

  assign cmd.op     = op_q;
  assign cmd.commit = commit && (status == ST_OK);

  // count update
  always_comb begin
    count_d = count_q;
    if (cmd.commit) begin
      case (op_q) inside
        OP_INSERT, OP_APPEND: count_d = count_q + CNT_BITS'(1);
        OP_REMOVE:            count_d = count_q - CNT_BITS'(1);
        default:              count_d = count_q;
      endcase
    end
  end

  // row of cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] prev_val, next_val;
    if (i == 0) begin : g_first
      assign prev_val = cell_val[i];
    end else begin : g_prev
      assign prev_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_next
      assign next_val = cell_val[i+1];
    end

    plec_cell #(
      .POS       (i),
      .ENTRY_BITS(ENTRY_BITS),
      .CNT_BITS  (CNT_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .ia_i      (ia_q),
      .ib_i      (ib_q),
      .count_i   (count_q),
      .wr_value_i(wr_value_q),
      .val_a_i   (val_a),
      .val_b_i   (val_b),
      .prev_i    (prev_val),
      .next_i    (next_val),
      .value_o   (cell_val[i]),
      .sel_a_o   (sel_a[i]),
      .sel_b_o   (sel_b[i])
    );
  end

  // read buses: each cell drives only when its position matches
  always_comb begin
    val_a = '0;
    val_b = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      val_a = val_a | sel_a[k];
      val_b = val_b | sel_b[k];
    end
  end

  // response payload
  assign rd_value = ((status == ST_OK) && (op_q == OP_READ || op_q == OP_REMOVE))
                    ? val_a : '0;
  assign rd_ext   = {{VALUE_BITS{1'b0}}, rd_value};
  assign cnt_ext  = {{COUNT_BITS{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_value_q  <= rd_ext[VALUE_BITS-1:0];
      out_count_q  <= cnt_ext[COUNT_BITS-1:0];
      out_status_q <= status;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.status      = out_status_q;

endmodule

FILE: src/plec_cell.sv
// one list cell: holds the entry at a fixed position and trades with its neighbors
module plec_cell #(
  parameter int POS        = 0,
  parameter int ENTRY_BITS = plec_pkg::ENTRY_BITS_DEF,
  parameter int CNT_BITS   = 8
) (
  input  logic                          clk_i,
  input  plec_pkg::cell_cmd_t           cmd_i,
  input  logic [plec_pkg::INDEX_BITS-1:0] ia_i,
  input  logic [plec_pkg::INDEX_BITS-1:0] ib_i,
  input  logic [CNT_BITS-1:0]           count_i,
  input  logic [ENTRY_BITS-1:0]         wr_value_i,
  input  logic [ENTRY_BITS-1:0]         val_a_i,
  input  logic [ENTRY_BITS-1:0]         val_b_i,
  input  logic [ENTRY_BITS-1:0]         prev_i,
  input  logic [ENTRY_BITS-1:0]         next_i,
  output logic [ENTRY_BITS-1:0]         value_o,
  output logic [ENTRY_BITS-1:0]         sel_a_o,
  output logic [ENTRY_BITS-1:0]         sel_b_o
);
  import plec_pkg::*;

  logic [ENTRY_BITS-1:0] entry_q, entry_d;
  logic                  at_a, at_b, above_a, at_end;

  // position compares against the request
  assign at_a    = (32'(ia_i) == POS);
  assign at_b    = (32'(ib_i) == POS);
  assign above_a = (POS > 32'(ia_i));
  assign at_end  = (32'(count_i) == POS);

  // contributions to the shared read buses
  assign sel_a_o = at_a ? entry_q : '0;
  assign sel_b_o = at_b ? entry_q : '0;
  assign value_o = entry_q;

  // next entry: shift from a neighbor, load, or swap
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.commit) begin
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (at_a) begin
            entry_d = wr_value_i;
          end else if (above_a) begin
            entry_d = prev_i;
          end
        end
        OP_APPEND: begin
          if (at_end) begin
            entry_d = wr_value_i;
          end
        end
        OP_REMOVE: begin
          if (at_a || above_a) begin
            entry_d = next_i;
          end
        end
        OP_SWAP: begin
          if (at_a) begin
            entry_d = val_b_i;
          end else if (at_b) begin
            entry_d = val_a_i;
          end
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: tb/sv/plec_list_checker.sv
`timescale 1ns / 1ps
// list checker: watches both channels, predicts each response and compares it
module plec_list_checker #(
  parameter int CAPACITY = plec_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic                             req_ready_i,
  input  logic [plec_pkg::OP_BITS-1:0]     req_op_i,
  input  logic [plec_pkg::INDEX_BITS-1:0]  req_index_i,
  input  logic [plec_pkg::INDEX_BITS-1:0]  req_index_b_i,
  input  logic [plec_pkg::VALUE_BITS-1:0]  req_value_i,
  input  logic                             rsp_valid_i,
  input  logic                             rsp_ready_i,
  input  logic [plec_pkg::VALUE_BITS-1:0]  rsp_read_value_i,
  input  logic [plec_pkg::COUNT_BITS-1:0]  rsp_entry_count_i,
  input  logic [plec_pkg::STATUS_BITS-1:0] rsp_status_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import plec_pkg::*;

  // one predicted response
  typedef struct packed {
    logic [VALUE_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0]  entry_count;
    logic [STATUS_BITS-1:0] status;
  } list_result_t;

  // shadow copy of the list
  logic [VALUE_BITS-1:0] shadow_entries [CAPACITY];
  int unsigned           shadow_count;
  list_result_t          expected_q [$];

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // apply one request to the shadow list and return the response it gives
  function automatic list_result_t apply_request(input logic [OP_BITS-1:0] op,
                                                 input logic [INDEX_BITS-1:0] ia,
                                                 input logic [INDEX_BITS-1:0] ib,
                                                 input logic [VALUE_BITS-1:0] val);
    list_result_t          res;
    logic [VALUE_BITS-1:0] tmp;
    int                    k;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_INSERT: begin
        // index check first, then capacity
        if (ia >= shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_count; k > ia; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[ia] = val;
          shadow_count++;
        end
      end
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (ia >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = shadow_entries[ia];
          for (k = ia; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (ia >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_entries[ia];
      end
      OP_SWAP: begin
        if (ia >= shadow_count || ib >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          tmp                = shadow_entries[ia];
          shadow_entries[ia] = shadow_entries[ib];
          shadow_entries[ib] = tmp;
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.entry_count = COUNT_BITS'(shadow_count);
    return res;
  endfunction

  // compare responses first, then predict new requests
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t predicted;
    if (!rst_ni) begin
      shadow_count = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected response, status", int'(rsp_status_i), 0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_read_value_i !== want.read_value)
            report_mismatch("read_value", int'(rsp_read_value_i), int'(want.read_value));
          if (rsp_entry_count_i !== want.entry_count)
            report_mismatch("entry_count", int'(rsp_entry_count_i), int'(want.entry_count));
          if (rsp_status_i !== want.status)
            report_mismatch("status", int'(rsp_status_i), int'(want.status));
        end
      end
      if (req_valid_i && req_ready_i) begin
        predicted  = apply_request(req_op_i, req_index_i, req_index_b_i, req_value_i);
        expected_q = {expected_q, predicted};
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the list engine testbench: clock, reset, request stimulus and verdict
module tb_top;
  import plec_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 275;
  localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = OP_SWAP + 3'd1;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   src_idle_pct = 0;
  int   rsp_stall_pct = 0;
  int   list_count = 0;   // entries held, tracked to keep indexes mostly in range
  bit   growing = 1'b1;

  plec_req_if req_if ();
  plec_rsp_if rsp_if ();

  positional_list_engine_core #(
    .CAPACITY  (CAPACITY),
    .ENTRY_BITS(ENTRY_BITS_DEF)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  plec_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_op_i         (req_if.op),
    .req_index_i      (req_if.index),
    .req_index_b_i    (req_if.index_b),
    .req_value_i      (req_if.entry_value),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_read_value_i (rsp_if.read_value),
    .rsp_entry_count_i(rsp_if.entry_count),
    .rsp_status_i     (rsp_if.status),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // response side stalls at random
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // drive one request and wait for its transfer
  task automatic send_req(input logic [OP_BITS-1:0] op, input logic [INDEX_BITS-1:0] ia,
                          input logic [INDEX_BITS-1:0] ib, input logic [VALUE_BITS-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.index       <= ia;
    req_if.index_b     <= ib;
    req_if.entry_value <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // keep the count in step with the transfer
    case (op)
      OP_INSERT: if (ia < list_count && list_count < CAPACITY) list_count++;
      OP_APPEND: if (list_count < CAPACITY) list_count++;
      OP_REMOVE: if (ia < list_count) list_count--;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // position that is mostly inside the list, sometimes anywhere
  function automatic logic [INDEX_BITS-1:0] pick_index();
    if (list_count > 0 && $urandom_range(9) != 0)
      return INDEX_BITS'($urandom_range(list_count - 1, 0));
    return INDEX_BITS'($urandom_range(127, 0));
  endfunction

  // random request biased toward filling or draining the list
  task automatic send_random();
    logic [OP_BITS-1:0] op;
    int                 r;
    if (growing && list_count == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
    if (!growing && list_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
    r = $urandom_range(99);
    if (r < 4) op = OP_SPARE_FIRST + 3'($urandom_range(2));
    else if (r < 17) op = OP_READ;
    else if (r < 30) op = OP_SWAP;
    else if (r < 40) op = growing ? OP_REMOVE : OP_APPEND;
    else if (r < 48) op = growing ? OP_REMOVE : OP_INSERT;
    else if (growing) op = (r < 75) ? OP_APPEND : OP_INSERT;
    else op = OP_REMOVE;
    send_req(op, pick_index(), pick_index(), 8'($urandom));
  endtask

  // stimulus and verdict
  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_READ;
    req_if.index       = '0;
    req_if.index_b     = '0;
    req_if.entry_value = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: every positional request is out of range, append works
    send_req(OP_READ,   7'd0, 7'd0, 8'h00);
    send_req(OP_REMOVE, 7'd0, 7'd0, 8'h00);
    send_req(OP_INSERT, 7'd0, 7'd0, 8'h11);
    send_req(OP_SWAP,   7'd0, 7'd0, 8'h00);
    send_req(OP_APPEND, 7'd0, 7'd0, 8'h00);
    send_req(OP_APPEND, 7'd127, 7'd127, 8'hFF);
    // insert at front, at last position, and at count which is refused
    send_req(OP_INSERT, 7'd0, 7'd0, 8'hA5);
    send_req(OP_INSERT, 7'd2, 7'd0, 8'h5A);
    send_req(OP_INSERT, 7'd4, 7'd0, 8'h33);
    send_req(OP_READ,   7'd3, 7'd0, 8'h00);
    send_req(OP_READ,   7'd127, 7'd0, 8'h00);
    // swaps: plain, same position, either index out of range
    send_req(OP_SWAP,   7'd0, 7'd3, 8'h00);
    send_req(OP_SWAP,   7'd1, 7'd1, 8'h00);
    send_req(OP_SWAP,   7'd0, 7'd127, 8'h00);
    send_req(OP_SWAP,   7'd127, 7'd0, 8'h00);
    // spare codes with every field at its top
    send_req(OP_SPARE_FIRST,        7'd127, 7'd127, 8'hFF);
    send_req(OP_SPARE_FIRST + 3'd1, 7'd127, 7'd127, 8'hFF);
    send_req(OP_SPARE_FIRST + 3'd2, 7'd127, 7'd127, 8'hFF);
    // remove last, first and middle
    send_req(OP_REMOVE, 7'd3, 7'd0, 8'h00);
    send_req(OP_REMOVE, 7'd0, 7'd0, 8'h00);
    send_req(OP_READ,   7'd0, 7'd0, 8'h00);
    send_req(OP_READ,   7'd1, 7'd0, 8'h00);
    send_req(OP_APPEND, 7'd0, 7'd0, 8'h80);
    send_req(OP_REMOVE, 7'd1, 7'd0, 8'h00);

    // random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin src_idle_pct = 76; rsp_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rsp_stall_pct = 76; end
        default: begin src_idle_pct = 33; rsp_stall_pct = 33; end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end
    req_if.valid <= 1'b0;

    // drain and let any stray response show up
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/plec_pkg.sv
src/plec_req_if.sv
src/plec_rsp_if.sv
src/plec_cell.sv
src/positional_list_engine_core.sv
tb/sv/plec_list_checker.sv
tb/sv/tb_top.sv
